// ----- design/piwe_pkg.sv -----
// shared types, constants and codes of the prefix index word expander
package piwe_pkg;

    // dimensions
    localparam int DICT_ENTRIES_DEF = 256;
    localparam int MAX_WORD_LEN_DEF = 32;
    localparam int QUEUE_DEPTH      = 2;

    // field widths
    localparam int CP_W    = 21;
    localparam int CMD_W   = 2;
    localparam int ENT_W   = 8;
    localparam int POS_IN_W = 5;
    localparam int WLEN_W  = 6;
    localparam int ACC_W   = 16;
    localparam int CNT_W   = 9;
    localparam int CFG_IDX_W = 2;

    // character constants
    localparam logic [CP_W-1:0]  CHAR_ZERO    = 21'd48;
    localparam logic [CP_W-1:0]  CHAR_NINE    = 21'd57;
    localparam logic [CP_W-1:0]  PREFIX_RESET = 21'd64;
    localparam logic [ACC_W-1:0] INDEX_MAX    = 16'hFFFF;
    localparam logic [3:0]       RADIX        = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_CHAR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FROM_ONE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEXT    = 2'd0,
        CMD_WR_CHAR = 2'd1,
        CMD_WR_LEN  = 2'd2,
        CMD_END     = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd                command;
        logic [CP_W-1:0]     character;
        logic [ENT_W-1:0]    entry_index;
        logic [POS_IN_W-1:0] char_position;
        logic [WLEN_W-1:0]   word_length;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] out_char;
        logic            last;
    } t_out_item;

    // work handed from the parser to the executor
    typedef enum logic [1:0] {
        OP_EMIT    = 2'd0,
        OP_EXPAND  = 2'd1,
        OP_WR_CHAR = 2'd2,
        OP_WR_LEN  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic [CP_W-1:0]     ch;
        logic                tail;
        logic [ACC_W-1:0]    key;
        logic [POS_IN_W-1:0] pos;
        logic [WLEN_W-1:0]   wlen;
    } t_op;

    typedef struct packed {
        logic [CP_W-1:0]  prefix_char;
        logic             from_one;
        logic [CNT_W-1:0] entry_count;
    } t_cfg;

endpackage

// ----- design/piwe_ram.sv -----
// generic single write port ram with registered read
module piwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/piwe_queue.sv -----
// short op queue between parser and executor
module piwe_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  piwe_pkg::t_op i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output piwe_pkg::t_op o_op
);
    import piwe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_op              r_slot [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_op;
        end
    end

endmodule

// ----- design/piwe_front.sv -----
// front end: accepts beats, tracks prefix and index parsing, issues ops
module piwe_front #(
    parameter int DICT_ENTRIES = piwe_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_WORD_LEN = piwe_pkg::MAX_WORD_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  piwe_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  piwe_pkg::t_in_item i_item,
    output logic               o_push,
    output piwe_pkg::t_op      o_op
);
    import piwe_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_PREFIX = 3'b010,
        MODE_DIGITS = 3'b100
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [ACC_W-1:0] r_acc, n_acc;

    logic              is_digit;
    logic              is_prefix;
    logic [3:0]        digit_val;
    logic [ACC_W+3:0]  acc_next;
    logic [ACC_W:0]    key_ext;
    logic              expand_ok;
    logic              push;
    t_op               op;

    assign is_digit  = (i_item.character >= CHAR_ZERO) && (i_item.character <= CHAR_NINE);
    assign is_prefix = (i_item.character == i_cfg.prefix_char);
    assign digit_val = 4'(i_item.character - CHAR_ZERO);

    // times ten plus digit, with room for the saturation check
    assign acc_next = ((r_mode == MODE_DIGITS) ? (ACC_W+4)'(r_acc) * (ACC_W+4)'(RADIX) : '0)
                      + (ACC_W+4)'(digit_val);

    // one-based mode shifts the index down by one; zero names nothing
    assign key_ext = i_cfg.from_one ? ((ACC_W+1)'(r_acc) - 1'b1) : (ACC_W+1)'(r_acc);
    assign expand_ok = !(i_cfg.from_one && (r_acc == '0))
                       && (key_ext < (ACC_W+1)'(i_cfg.entry_count))
                       && (32'(key_ext) < 32'(DICT_ENTRIES));

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        push    = 1'b0;
        op.kind = OP_EMIT;
        op.ch   = i_item.character;
        op.tail = 1'b0;
        op.key  = ACC_W'(i_item.entry_index);
        op.pos  = i_item.char_position;
        op.wlen = i_item.word_length;
        case (i_item.command)
            CMD_WR_CHAR: begin
                op.kind = OP_WR_CHAR;
                push = (32'(i_item.entry_index) < 32'(DICT_ENTRIES))
                       && (32'(i_item.char_position) < 32'(MAX_WORD_LEN));
            end
            CMD_WR_LEN: begin
                op.kind = OP_WR_LEN;
                push = (32'(i_item.entry_index) < 32'(DICT_ENTRIES));
            end
            CMD_END: begin
                op.kind = OP_EXPAND;
                op.key  = key_ext[ACC_W-1:0];
                push    = (r_mode == MODE_DIGITS) && expand_ok;
                n_mode  = MODE_IDLE;
                n_acc   = '0;
            end
            CMD_TEXT: begin
                if (r_mode == MODE_IDLE) begin
                    if (is_prefix) begin
                        n_mode = MODE_PREFIX;
                        n_acc  = '0;
                    end else begin
                        push = 1'b1;
                    end
                end else if (is_digit) begin
                    n_acc  = (acc_next > (ACC_W+4)'(INDEX_MAX)) ? INDEX_MAX
                                                                : acc_next[ACC_W-1:0];
                    n_mode = MODE_DIGITS;
                end else if (r_mode == MODE_PREFIX) begin
                    // doubled prefix or lone prefix: the character goes out
                    n_mode = MODE_IDLE;
                    n_acc  = '0;
                    push   = 1'b1;
                end else begin
                    n_acc  = '0;
                    n_mode = is_prefix ? MODE_PREFIX : MODE_IDLE;
                    if (expand_ok) begin
                        op.kind = OP_EXPAND;
                        op.key  = key_ext[ACC_W-1:0];
                        op.tail = !is_prefix;
                        push    = 1'b1;
                    end else begin
                        push = !is_prefix;
                    end
                end
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_acc  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
        end
    end

    assign o_push = i_accept && push;
    assign o_op   = op;

endmodule

// ----- design/piwe_back.sv -----
// back end: dictionary stores, word read-out and output register
module piwe_back #(
    parameter int DICT_ENTRIES = piwe_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_WORD_LEN = piwe_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  piwe_pkg::t_op       i_op,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output piwe_pkg::t_out_item o_out_data
);
    import piwe_pkg::*;

    localparam int KW    = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int CHARS = DICT_ENTRIES * MAX_WORD_LEN;
    localparam int CA_W  = (CHARS > 1) ? $clog2(CHARS) : 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_LEN   = 4'b0010,
        ST_CHARS = 4'b0100,
        ST_TAIL  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [KW-1:0]     r_k, n_k;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic              r_tail, n_tail;
    logic [CP_W-1:0]   r_tail_char, n_tail_char;

    logic              r_slot_vld, r_slot_lit, r_slot_last;
    logic [CP_W-1:0]   r_slot_char;
    logic              r_out_vld;
    t_out_item         r_out;

    logic              slot_move, slot_free;
    logic              slot_load, slot_lit, slot_last;
    logic [CP_W-1:0]   slot_char;
    logic              pop, char_we, char_re, len_we, len_re;
    logic              final_char;
    logic [31:0]       wlen_sat;
    logic [CA_W-1:0]   char_waddr, char_raddr;
    logic [CP_W-1:0]   char_rdata;
    logic [LEN_W-1:0]  len_rdata;

    assign slot_move = r_slot_vld && (!r_out_vld || !i_out_stall);
    assign slot_free = !r_slot_vld || slot_move;

    assign wlen_sat   = (32'(i_op.wlen) > 32'(MAX_WORD_LEN)) ? 32'(MAX_WORD_LEN)
                                                             : 32'(i_op.wlen);
    assign char_waddr = CA_W'(32'(i_op.key[KW-1:0]) * 32'(MAX_WORD_LEN)) + CA_W'(i_op.pos);
    assign char_raddr = CA_W'(32'(r_k) * 32'(MAX_WORD_LEN)) + CA_W'(r_pos);
    assign final_char = ((LEN_W+1)'(r_pos) + 1'b1) == (LEN_W+1)'(r_len);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_len       = r_len;
        n_pos       = r_pos;
        n_tail      = r_tail;
        n_tail_char = r_tail_char;
        pop         = 1'b0;
        char_we     = 1'b0;
        char_re     = 1'b0;
        len_we      = 1'b0;
        len_re      = 1'b0;
        slot_load   = 1'b0;
        slot_lit    = 1'b1;
        slot_last   = 1'b1;
        slot_char   = i_op.ch;
        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    case (i_op.kind)
                        OP_WR_CHAR: begin
                            char_we = 1'b1;
                            pop     = 1'b1;
                        end
                        OP_WR_LEN: begin
                            len_we = 1'b1;
                            pop    = 1'b1;
                        end
                        OP_EMIT: begin
                            if (slot_free) begin
                                slot_load = 1'b1;
                                pop       = 1'b1;
                            end
                        end
                        OP_EXPAND: begin
                            len_re      = 1'b1;
                            pop         = 1'b1;
                            n_k         = i_op.key[KW-1:0];
                            n_tail      = i_op.tail;
                            n_tail_char = i_op.ch;
                            n_state     = ST_LEN;
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_LEN: begin
                if (len_rdata == '0) begin
                    n_state = r_tail ? ST_TAIL : ST_IDLE;
                end else begin
                    n_len   = len_rdata;
                    n_pos   = '0;
                    n_state = ST_CHARS;
                end
            end
            ST_CHARS: begin
                if (slot_free) begin
                    char_re   = 1'b1;
                    slot_load = 1'b1;
                    slot_lit  = 1'b0;
                    slot_last = final_char && !r_tail;
                    n_pos     = r_pos + 1'b1;
                    if (final_char) begin
                        n_state = r_tail ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (slot_free) begin
                    slot_load = 1'b1;
                    slot_char = r_tail_char;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    piwe_ram #(
        .WIDTH (CP_W),
        .DEPTH (CHARS),
        .AW    (CA_W)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (i_op.ch),
        .i_re    (char_re),
        .i_raddr (char_raddr),
        .o_rdata (char_rdata)
    );

    piwe_ram #(
        .WIDTH (LEN_W),
        .DEPTH (DICT_ENTRIES),
        .AW    (KW)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (i_op.key[KW-1:0]),
        .i_wdata (wlen_sat[LEN_W-1:0]),
        .i_re    (len_re),
        .i_raddr (i_op.key[KW-1:0]),
        .o_rdata (len_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_slot_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_load) begin
                r_slot_vld <= 1'b1;
            end else if (slot_move) begin
                r_slot_vld <= 1'b0;
            end
            if (slot_move) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k         <= n_k;
        r_len       <= n_len;
        r_pos       <= n_pos;
        r_tail      <= n_tail;
        r_tail_char <= n_tail_char;
        if (slot_load) begin
            r_slot_lit  <= slot_lit;
            r_slot_last <= slot_last;
            r_slot_char <= slot_char;
        end
        if (slot_move) begin
            r_out.out_char <= r_slot_lit ? r_slot_char : char_rdata;
            r_out.last     <= r_slot_last;
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- design/prefix_index_word_expander_unit.sv -----
// plain characters pass the op queue, output slot and output register; one beat per cycle
// sustained while the output is not stalled; word expansion: the read-out engine reads the
// length, then one character ram read per cycle while the slot is free, then any trailing char
// the parser keeps accepting into a two-entry op queue while the read-out engine is busy
// synchronous active-low reset: parsing idle, queue empty, registers at their defaults;
// dictionary rams are not cleared and must be loaded before use
module prefix_index_word_expander_unit #(
    parameter int DICT_ENTRIES = piwe_pkg::DICT_ENTRIES_DEF,
    parameter int MAX_WORD_LEN = piwe_pkg::MAX_WORD_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  piwe_pkg::t_in_item            i_in_data,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output piwe_pkg::t_out_item           o_out_data,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [piwe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [piwe_pkg::CP_W-1:0]     i_cfg_data
);
    import piwe_pkg::*;

    t_cfg r_cfg;
    logic in_accept;
    logic q_full, q_valid, q_pop, push;
    t_op  push_op, q_op;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prefix_char <= PREFIX_RESET;
            r_cfg.from_one    <= 1'b0;
            r_cfg.entry_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PREFIX_CHAR: r_cfg.prefix_char <= i_cfg_data;
                CFG_FROM_ONE:    r_cfg.from_one    <= i_cfg_data[0];
                CFG_ENTRY_COUNT: r_cfg.entry_count <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // an input beat is taken whenever the op queue has room
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // parser: decides per beat what work (if any) goes to the back end
    piwe_front #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (in_accept),
        .i_item   (i_in_data),
        .o_push   (push),
        .o_op     (push_op)
    );

    // decoupling queue
    piwe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    // executor: dictionary writes, word read-out, output beats
    piwe_back #(
        .DICT_ENTRIES (DICT_ENTRIES),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- tb/prefix_index_word_expander_unit_tb.sv -----
// self-checking testbench of the prefix index word expander unit
module prefix_index_word_expander_unit_tb;
    import piwe_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 48;   // covers the longest expansion, plus slack
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 52;
    localparam int LOADED_LOW    = 16;   // entries loaded up front besides the last one

    // parser state of the predictor
    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_PREFIX,
        PARSE_DIGITS
    } t_parse;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      out_stall = 1'b0;
    logic      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CP_W-1:0]      cfg_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;

    // predictor copy of registers, parser and dictionary
    t_cfg             dict_cfg = '{prefix_char: PREFIX_RESET, from_one: 1'b0, entry_count: '0};
    t_parse           parse_state = PARSE_IDLE;
    logic [ACC_W-1:0] idx_acc = '0;
    logic [CP_W-1:0]  word_text [DICT_ENTRIES_DEF][MAX_WORD_LEN_DEF];
    logic [WLEN_W-1:0] word_len [DICT_ENTRIES_DEF];

    // stimulus-side record of which dictionary slots hold data
    logic [MAX_WORD_LEN_DEF-1:0] char_loaded [DICT_ENTRIES_DEF];
    bit                          len_loaded [DICT_ENTRIES_DEF];

    t_in_item  items_to_send [$];
    t_out_item due_beats [$];
    t_out_item fresh_beats [$];
    t_out_item want_beat;

    int  queued_items = 0;
    int  accepted_items = 0;
    int  checked_beats = 0;
    int  mismatches = 0;
    int  settings_used = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_wanted = 1'b0;
    bit  hold_taken = 1'b0;

    prefix_index_word_expander_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void add_char(logic [CP_W-1:0] ch);
        t_out_item beat;
        beat.out_char = ch;
        beat.last     = 1'b0;
        fresh_beats.insert(fresh_beats.size(), beat);
    endfunction

    // append the word named by the pending index, if it names an entry below the entry count and the dictionary size
    function automatic void add_word();
        int key;
        int len;
        key = int'(idx_acc);
        if (dict_cfg.from_one) begin
            if (key == 0) return;
            key--;
        end
        if (key >= int'(dict_cfg.entry_count) || key >= DICT_ENTRIES_DEF) return;
        len = int'(word_len[key]);
        for (int i = 0; i < len; i++) add_char(word_text[key][i]);
    endfunction

    // update the predictor with one accepted beat and queue the beats it causes
    function automatic void expand_item(t_in_item it);
        logic is_digit;
        int   sum;
        fresh_beats.delete();
        is_digit = it.character >= CHAR_ZERO && it.character <= CHAR_NINE;
        case (it.command)
            CMD_WR_CHAR: begin
                word_text[it.entry_index][it.char_position] = it.character;
            end
            CMD_WR_LEN: begin
                word_len[it.entry_index] = (it.word_length > MAX_WORD_LEN_DEF) ?
                    WLEN_W'(MAX_WORD_LEN_DEF) : it.word_length;
            end
            CMD_END: begin
                // a pending index is flushed, a lone prefix just vanishes
                if (parse_state == PARSE_DIGITS) add_word();
                parse_state = PARSE_IDLE;
                idx_acc = '0;
            end
            default: begin
                if (parse_state != PARSE_IDLE) begin
                    // digits win over the prefix compare right after a prefix
                    if (is_digit) begin
                        sum = int'(it.character) - int'(CHAR_ZERO);
                        if (parse_state == PARSE_DIGITS) sum = sum + int'(idx_acc) * int'(RADIX);
                        idx_acc = (sum > int'(INDEX_MAX)) ? INDEX_MAX : ACC_W'(sum);
                        parse_state = PARSE_DIGITS;
                    end else if (parse_state == PARSE_PREFIX) begin
                        // doubled prefix gives one prefix, any other char drops the prefix
                        parse_state = PARSE_IDLE;
                        idx_acc = '0;
                        add_char(it.character);
                    end else begin
                        add_word();
                        idx_acc = '0;
                        if (it.character == dict_cfg.prefix_char) begin
                            parse_state = PARSE_PREFIX;
                        end else begin
                            parse_state = PARSE_IDLE;
                            add_char(it.character);
                        end
                    end
                end else if (it.character == dict_cfg.prefix_char) begin
                    parse_state = PARSE_PREFIX;
                    idx_acc = '0;
                end else begin
                    add_char(it.character);
                end
            end
        endcase
        if (fresh_beats.size() != 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
        foreach (fresh_beats[i]) due_beats.insert(due_beats.size(), fresh_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    function automatic logic [CP_W-1:0] any_char();
        case ($urandom_range(0, 3))
            0: return CP_W'($urandom_range(32, 126));
            1: return CP_W'($urandom_range(0, 1114111));
            2: return CP_W'($urandom);
            default: return CP_W'($urandom_range(0, 255));
        endcase
    endfunction

    // a character that neither continues an index nor starts one
    function automatic logic [CP_W-1:0] plain_char();
        logic [CP_W-1:0] ch;
        do begin
            ch = any_char();
        end while ((ch >= CHAR_ZERO && ch <= CHAR_NINE) || ch == dict_cfg.prefix_char);
        return ch;
    endfunction

    // free text never holds the prefix, so no index starts by chance
    function automatic logic [CP_W-1:0] text_char();
        logic [CP_W-1:0] ch;
        do begin
            ch = any_char();
        end while (ch == dict_cfg.prefix_char);
        return ch;
    endfunction

    function automatic logic [CP_W-1:0] digit_char();
        logic [CP_W-1:0] ch;
        do begin
            ch = CP_W'($urandom_range(48, 57));
        end while (ch == dict_cfg.prefix_char);
        return ch;
    endfunction

    // unused fields get random bits, the block must ignore them
    function automatic t_in_item make_item(t_cmd cmd, logic [CP_W-1:0] ch);
        t_in_item it;
        it.command       = cmd;
        it.character     = ch;
        it.entry_index   = ENT_W'($urandom);
        it.char_position = POS_IN_W'($urandom);
        it.word_length   = WLEN_W'($urandom);
        return it;
    endfunction

    function automatic void queue_item(t_in_item it);
        items_to_send.insert(items_to_send.size(), it);
        queued_items++;
    endfunction

    function automatic void push_text(logic [CP_W-1:0] ch);
        queue_item(make_item(CMD_TEXT, ch));
    endfunction

    function automatic void push_prefix();
        push_text(dict_cfg.prefix_char);
    endfunction

    function automatic void push_end();
        queue_item(make_item(CMD_END, any_char()));
    endfunction

    function automatic void push_char(int ent, int pos, logic [CP_W-1:0] ch);
        t_in_item it;
        it = make_item(CMD_WR_CHAR, ch);
        it.entry_index   = ENT_W'(ent);
        it.char_position = POS_IN_W'(pos);
        char_loaded[ent][pos] = 1'b1;
        queue_item(it);
    endfunction

    // a length is only set once every char it covers is loaded, so no expansion
    // ever reads an empty slot
    function automatic void push_len(int ent, int len);
        int       span;
        t_in_item it;
        span = (len > MAX_WORD_LEN_DEF) ? MAX_WORD_LEN_DEF : len;
        for (int p = 0; p < span; p++)
            if (!char_loaded[ent][p]) push_char(ent, p, any_char());
        it = make_item(CMD_WR_LEN, any_char());
        it.entry_index = ENT_W'(ent);
        it.word_length = WLEN_W'(len);
        len_loaded[ent] = 1'b1;
        queue_item(it);
    endfunction

    function automatic void push_number(int unsigned value, int zeros);
        string digits;
        digits = $sformatf("%0d", value);
        repeat (zeros) push_text(CHAR_ZERO);
        for (int i = 0; i < digits.len(); i++) push_text(CP_W'(digits[i]));
    endfunction

    // mostly indexes of loaded words, some just past the end, some that saturate, some zero in one-based mode
    function automatic int unsigned pick_index();
        int unsigned n;
        int unsigned k;
        int          r;
        n = dict_cfg.entry_count;
        r = $urandom_range(0, 99);
        if (r < 6) return 65535 + $urandom_range(0, 9999999);
        if (r < 14 || n == 0) return n + dict_cfg.from_one + $urandom_range(0, 3);
        if (r < 20 && dict_cfg.from_one) return 0;
        // entry 0 always has a length, so this ends
        do begin
            k = $urandom_range(0, n - 1);
        end while (!len_loaded[k]);
        return k + dict_cfg.from_one;
    endfunction

    // every chunk leaves the parser idle
    function automatic void push_random_chunk();
        int r;
        int t;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            // well-formed reference with a random way out of the digits
            push_prefix();
            push_number(pick_index(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
            t = $urandom_range(0, 3);
            if (t < 2) push_text(plain_char());
            else if (t == 2) push_end();
            else begin
                push_prefix();
                push_text(plain_char());
            end
        end else if (r < 65) begin
            repeat ($urandom_range(1, 4)) push_text(text_char());
        end else if (r < 72) begin
            push_prefix();
            push_prefix();
        end else if (r < 78) begin
            push_prefix();
            push_text(plain_char());
        end else if (r < 84) begin
            push_end();
        end else if (r < 90) begin
            push_char($urandom_range(0, 255), $urandom_range(0, 31), any_char());
        end else if (r < 95) begin
            push_len($urandom_range(0, 255), $urandom_range(0, 63));
        end else begin
            repeat ($urandom_range(1, 3)) push_text(digit_char());
        end
    endfunction

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PREFIX_CHAR: dict_cfg.prefix_char = value;
            CFG_FROM_ONE:    dict_cfg.from_one    = value[0];
            CFG_ENTRY_COUNT: dict_cfg.entry_count = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [CP_W-1:0] pfx, input logic ob,
                                 input logic [CNT_W-1:0] count);
        set_register(CFG_PREFIX_CHAR, pfx);
        set_register(CFG_FROM_ONE, CP_W'(ob));
        set_register(CFG_ENTRY_COUNT, CP_W'(count));
        settings_used++;
    endtask

    // every beat out and every beat back, then room for a load still in flight
    task automatic settle();
        while (items_to_send.size() != 0 || in_valid || due_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct = sender;
        stall_pct     = receiver;
    endtask

    task automatic run_phase(input logic [CP_W-1:0] pfx, input logic ob,
                             input logic [CNT_W-1:0] count, input int sender,
                             input int receiver, input bit squeeze);
        int target;
        apply_setting(pfx, ob, count);
        set_idling(sender, receiver);
        hold_wanted = squeeze;
        target = queued_items + PHASE_ITEMS;
        while (queued_items < target) push_random_chunk();
        settle();
    endtask

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("error: %s", what);
    endfunction

    // ------------------------------------------------------------------
    // input side: offer queued beats, run the predictor on each accepted one
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                expand_item(in_data);
                accepted_items++;
            end
            // a stalled beat stays put, otherwise pick the next one or idle
            if (in_valid && in_stall) begin
                in_valid <= 1'b1;
            end else if (items_to_send.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_data  <= items_to_send.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // output stall: random, plus one long hold that backs the block up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_wanted && !hold_taken) begin
            out_stall  <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // output side: compare each accepted beat with the oldest one due
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            checked_beats++;
            if (due_beats.size() == 0) begin
                flag_mismatch($sformatf("beat with nothing due: char %h last %b",
                                        out_data.out_char, out_data.last));
            end else begin
                want_beat = due_beats.pop_front();
                if (want_beat.out_char !== out_data.out_char || want_beat.last !== out_data.last)
                    flag_mismatch($sformatf("char expected %h got %h, last expected %b got %b",
                                            want_beat.out_char, out_data.out_char,
                                            want_beat.last, out_data.last));
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due", cycle_count,
                     due_beats.size());
            $display("prefix_index_word_expander_unit: mismatch");
            $finish;
        end
    end

    initial begin
        foreach (char_loaded[i]) char_loaded[i] = '0;
        foreach (len_loaded[i]) len_loaded[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // load the low entries with short words, some empty, and the last entry full
        // with an oversized length that must saturate
        for (int e = 0; e < LOADED_LOW; e++) begin
            if (e % 4 == 3) push_len(e, 0);
            else push_len(e, $urandom_range(1, 5));
        end
        push_len(DICT_ENTRIES_DEF - 1, 63);
        settle();

        // directed corners at the default prefix, zero-based, full dictionary
        apply_setting(PREFIX_RESET, 1'b0, CNT_W'(DICT_ENTRIES_DEF));
        push_text('0);
        push_text(21'h10FFFF);
        push_text(21'h1FFFFF);
        push_end();                              // nothing pending
        push_prefix(); push_number(5, 0); push_text(21'h78);
        push_prefix(); push_prefix();            // doubled prefix
        push_prefix(); push_text(21'h42);        // lone prefix
        push_prefix(); push_number(12, 0); push_end();
        push_prefix(); push_end();               // lone prefix at end of text
        push_prefix(); push_number(99999, 0); push_text(21'h63);   // saturated index
        push_prefix(); push_number(255, 0); push_text(21'h7A);     // longest word then a char
        settle();

        // random phases over register extremes and idling patterns
        run_phase(PREFIX_RESET, 1'b0, CNT_W'(DICT_ENTRIES_DEF), 0, 0, 1'b0);
        run_phase(21'h10FFFF, 1'b1, CNT_W'(1), 87, 0, 1'b0);
        run_phase(CP_W'(53), 1'b0, CNT_W'(200), 0, 87, 1'b1);   // digit as prefix, long hold
        run_phase('0, 1'b1, CNT_W'(DICT_ENTRIES_DEF), 8, 8, 1'b0);
        run_phase(PREFIX_RESET, 1'b1, '0, 0, 0, 1'b0);
        run_phase(CP_W'($urandom_range(33, 126)), 1'(($urandom_range(0, 1))),
                  CNT_W'($urandom_range(1, DICT_ENTRIES_DEF)), 87, 0, 1'b0);

        $display("covered %0d input beats (loads, text, end markers) under %0d register settings",
                 accepted_items, settings_used);
        $display("compared %0d output beats, %0d mismatches", checked_beats, mismatches);
        if (mismatches == 0) begin
            $display("prefix_index_word_expander_unit: match");
        end else begin
            $display("prefix_index_word_expander_unit: mismatch");
        end
        $finish;
    end

endmodule
